FILE: rtl/core/qcmr_pkg.sv
package qcmr_pkg;

  localparam int CodeW    = 8;
  localparam int ZpW      = 9;
  localparam int ShiftW   = 6;
  localparam int WordW    = 32;
  localparam int AddrW    = 5;
  localparam int OperandW = 10;             // widened byte minus zero point
  localparam int ProductW = 2 * OperandW;

  // register indexes (byte address / 4)
  localparam logic [2:0] RegActZp    = 3'd0;
  localparam logic [2:0] RegWtZp     = 3'd1;
  localparam logic [2:0] RegOutZp    = 3'd2;
  localparam logic [2:0] RegActUns   = 3'd3;
  localparam logic [2:0] RegWtUns    = 3'd4;
  localparam logic [2:0] RegOutUns   = 3'd5;
  localparam logic [2:0] RegShift    = 3'd6;

  localparam logic [ShiftW-1:0] ShiftReset = 6'd31;

  localparam int OutMinSigned   = -128;
  localparam int OutMaxSigned   = 127;
  localparam int OutMaxUnsigned = 255;

  typedef struct packed {
    logic [ZpW-1:0] act_zp;
    logic [ZpW-1:0] wt_zp;
    logic           act_uns;
    logic           wt_uns;
  } mac_cfg_t;

  typedef struct packed {
    logic [ZpW-1:0]    out_zp;
    logic              out_uns;
    logic [ShiftW-1:0] shift;
  } rq_cfg_t;

  typedef struct packed {
    logic [WordW-1:0] sum;
    logic [WordW-1:0] mult;
  } rq_job_t;

endpackage

FILE: rtl/core/qcmr_if.sv
interface qcmr_tap_if;
  logic        valid;
  logic        ready;
  logic [7:0]  act_code;
  logic [7:0]  wt_code;
  logic        tap_valid;
  logic [31:0] bias_value;
  logic [31:0] channel_multiplier;
  logic        last_tap;

  modport source (
    output valid, act_code, wt_code, tap_valid, bias_value, channel_multiplier, last_tap,
    input  ready
  );
  modport sink (
    input  valid, act_code, wt_code, tap_valid, bias_value, channel_multiplier, last_tap,
    output ready
  );
endinterface

interface qcmr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_code;

  modport source (output valid, out_code, input ready);
  modport sink (input valid, out_code, output ready);
endinterface

FILE: rtl/core/qcmr_front.sv
module qcmr_front (
  input  logic               clk,
  input  logic               rst,
  input  qcmr_pkg::mac_cfg_t cfg,
  qcmr_tap_if.sink           tap,
  output logic               push,
  output qcmr_pkg::rq_job_t  push_data,
  input  logic               full
);

  localparam int OW = qcmr_pkg::OperandW;
  localparam int PW = qcmr_pkg::ProductW;
  localparam int WW = qcmr_pkg::WordW;

  logic [WW-1:0]        tap_sum;
  logic [WW-1:0]        tap_sum_next;
  logic                 accept;
  logic signed [OW-1:0] act_wide;
  logic signed [OW-1:0] wt_wide;
  logic signed [OW-1:0] act_op;
  logic signed [OW-1:0] wt_op;
  logic signed [PW-1:0] prod;
  logic [WW-1:0]        prod_ext;
  logic [WW-1:0]        sum_taps;

  assign tap.ready = !full;
  assign accept    = tap.valid && tap.ready;

  always_comb begin
    act_wide = cfg.act_uns ? $signed({2'b00, tap.act_code})
                           : $signed({{2{tap.act_code[7]}}, tap.act_code});
    wt_wide  = cfg.wt_uns  ? $signed({2'b00, tap.wt_code})
                           : $signed({{2{tap.wt_code[7]}}, tap.wt_code});
    act_op   = act_wide - $signed({cfg.act_zp[qcmr_pkg::ZpW-1], cfg.act_zp});
    wt_op    = wt_wide  - $signed({cfg.wt_zp[qcmr_pkg::ZpW-1], cfg.wt_zp});
    prod     = act_op * wt_op;
    prod_ext = {{(WW-PW){prod[PW-1]}}, prod};
    sum_taps = tap.tap_valid ? tap_sum + prod_ext : tap_sum;
    tap_sum_next = tap.last_tap ? '0 : sum_taps;
  end

  // last tap: bias goes in and the finished sum leaves for requantization
  assign push           = accept && tap.last_tap;
  assign push_data.sum  = sum_taps + tap.bias_value;
  assign push_data.mult = tap.channel_multiplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_sum <= '0;
    end else if (accept) begin
      tap_sum <= tap_sum_next;
    end
  end

`ifndef SYNTH
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    push |=> tap_sum == '0)
    else $error("accumulator not cleared after last tap");
`endif

endmodule

FILE: rtl/core/qcmr_queue.sv
module qcmr_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qcmr_pkg::rq_job_t push_data,
  output logic              full,
  input  logic              pop,
  output qcmr_pkg::rq_job_t pop_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  qcmr_pkg::rq_job_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = count == FULL_CNT;
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full job queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty job queue");
`endif

endmodule

FILE: rtl/core/qcmr_back.sv
module qcmr_back (
  input  logic              clk,
  input  logic              rst,
  input  qcmr_pkg::rq_cfg_t cfg,
  input  logic              empty,
  input  qcmr_pkg::rq_job_t pop_data,
  output logic              pop,
  qcmr_out_if.source        res
);

  localparam int WW = qcmr_pkg::WordW;
  localparam int HW = WW / 2;
  localparam int MW = WW + HW + 1;   // sum times one unsigned half
  localparam int PW = 2 * WW;
  localparam int TW = PW + 1;

  localparam logic signed [TW-1:0] LO_S = TW'(qcmr_pkg::OutMinSigned);
  localparam logic signed [TW-1:0] HI_S = TW'(qcmr_pkg::OutMaxSigned);
  localparam logic signed [TW-1:0] HI_U = TW'(qcmr_pkg::OutMaxUnsigned);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL_LO = 6'b000010,
    ST_MUL_HI = 6'b000100,
    ST_ADD    = 6'b001000,
    ST_SHIFT  = 6'b010000,
    ST_FIN    = 6'b100000
  } rq_state_t;

  rq_state_t                      state;
  logic [WW-1:0]                  sum_r;
  logic [WW-1:0]                  mult_r;
  logic signed [MW-1:0]           prod_lo;
  logic signed [MW-1:0]           prod_hi;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           quot;
  logic                           round_bit;
  logic                           sticky;
  logic                           out_valid;
  logic [qcmr_pkg::CodeW-1:0]     out_code;

  logic [HW-1:0]                  mul_half;
  logic signed [MW-1:0]           mul_res;
  logic [qcmr_pkg::ShiftW-1:0]    shift_m1;
  logic [PW-1:0]                  low_mask;
  logic signed [TW-1:0]           t_base;
  logic signed [TW-1:0]           t_round;
  logic signed [TW-1:0]           lo;
  logic signed [TW-1:0]           hi;
  logic signed [TW-1:0]           t_clamp;
  logic                           out_free;

  assign out_free = !out_valid || res.ready;
  assign pop      = (state == ST_IDLE) && !empty;

  // one 32x17 multiplier, used for each half of the multiplier in turn
  always_comb begin
    mul_half = (state == ST_MUL_LO) ? mult_r[HW-1:0] : mult_r[WW-1:HW];
    mul_res  = $signed(sum_r) * $signed({1'b0, mul_half});
    shift_m1 = cfg.shift - 1'b1;
    low_mask = (PW'(1) << shift_m1) - PW'(1);
  end

  // floor division plus zero point, then half away from zero on the sign of that sum
  always_comb begin
    t_base  = $signed({quot[PW-1], quot})
            + $signed({{(TW-qcmr_pkg::ZpW){cfg.out_zp[qcmr_pkg::ZpW-1]}}, cfg.out_zp});
    t_round = (round_bit && (!t_base[TW-1] || sticky)) ? t_base + TW'(1) : t_base;
    lo      = cfg.out_uns ? '0 : LO_S;
    hi      = cfg.out_uns ? HI_U : HI_S;
    if (t_round < lo) begin
      t_clamp = lo;
    end else if (t_round > hi) begin
      t_clamp = hi;
    end else begin
      t_clamp = t_round;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!empty) begin
          sum_r  <= pop_data.sum;
          mult_r <= pop_data.mult;
        end
      end
      ST_MUL_LO: prod_lo <= mul_res;
      ST_MUL_HI: prod_hi <= mul_res;
      ST_ADD: begin
        prod <= $signed({prod_hi[PW-HW-1:0], {HW{1'b0}}})
              + $signed({{(PW-MW){prod_lo[MW-1]}}, prod_lo});
      end
      ST_SHIFT: begin
        quot      <= prod >>> cfg.shift;
        round_bit <= (cfg.shift != '0) && prod[shift_m1];
        sticky    <= (cfg.shift != '0) && ((prod & low_mask) != '0);
      end
      default: ;
    endcase
    if (state == ST_FIN && out_free) begin
      out_code <= t_clamp[qcmr_pkg::CodeW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE:   if (!empty) state <= ST_MUL_LO;
        ST_MUL_LO: state <= ST_MUL_HI;
        ST_MUL_HI: state <= ST_ADD;
        ST_ADD:    state <= ST_SHIFT;
        ST_SHIFT:  state <= ST_FIN;
        ST_FIN:    if (out_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid    = out_valid;
  assign res.out_code = out_code;

`ifndef SYNTH
  a_mul_after_pop: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL_LO |-> $past(pop))
    else $error("multiply started without a job");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not presented");
`endif

endmodule

FILE: rtl/core/quantized_conv_mac_requantize.sv
// Channel  Dir  Kind       Payload
// tap      in   valid/rdy  act_code, wt_code, tap_valid, bias_value, channel_multiplier, last_tap
// res      out  valid/rdy  out_code
// apb      in   APB r/w    7 config registers at 4*i, pready tied high
//
// Taps are taken one per cycle while tap.ready is high; the MAC updates the accumulator in the cycle a word is taken.
// Each last tap queues one job; the requantizer takes a job only from idle and runs it on its
// shared 32x17 multiplier, low half then high half, plus add, shift and round/clamp steps.
// tap.ready drops only while the job queue (QUEUE_DEPTH entries) is full.
// rst (synchronous) clears the accumulator, queue, sequencer and output; shift resets to 31.
// A stalled result holds in the output register; the requantizer waits, then the queue fills.
module quantized_conv_mac_requantize #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  qcmr_tap_if.sink                    tap,
  qcmr_out_if.source                  res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qcmr_pkg::AddrW-1:0]  paddr,
  input  logic [qcmr_pkg::WordW-1:0]  pwdata,
  output logic [qcmr_pkg::WordW-1:0]  prdata,
  output logic                        pready
);

  localparam int ZW = qcmr_pkg::ZpW;
  localparam int SW = qcmr_pkg::ShiftW;

  logic [ZW-1:0]      act_zero_point;
  logic [ZW-1:0]      wt_zero_point;
  logic [ZW-1:0]      out_zero_point;
  logic               act_unsigned;
  logic               wt_unsigned;
  logic               out_unsigned;
  logic [SW-1:0]      requant_shift;

  logic               cfg_wr;
  logic [2:0]         reg_idx;
  qcmr_pkg::mac_cfg_t mac_cfg;
  qcmr_pkg::rq_cfg_t  rq_cfg;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  qcmr_pkg::rq_job_t  push_data;
  qcmr_pkg::rq_job_t  pop_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[qcmr_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      act_zero_point <= '0;
      wt_zero_point  <= '0;
      out_zero_point <= '0;
      act_unsigned   <= 1'b0;
      wt_unsigned    <= 1'b0;
      out_unsigned   <= 1'b0;
      requant_shift  <= qcmr_pkg::ShiftReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        qcmr_pkg::RegActZp:  act_zero_point <= pwdata[ZW-1:0];
        qcmr_pkg::RegWtZp:   wt_zero_point  <= pwdata[ZW-1:0];
        qcmr_pkg::RegOutZp:  out_zero_point <= pwdata[ZW-1:0];
        qcmr_pkg::RegActUns: act_unsigned   <= pwdata[0];
        qcmr_pkg::RegWtUns:  wt_unsigned    <= pwdata[0];
        qcmr_pkg::RegOutUns: out_unsigned   <= pwdata[0];
        qcmr_pkg::RegShift:  requant_shift  <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qcmr_pkg::RegActZp:  prdata = {{(qcmr_pkg::WordW-ZW){1'b0}}, act_zero_point};
      qcmr_pkg::RegWtZp:   prdata = {{(qcmr_pkg::WordW-ZW){1'b0}}, wt_zero_point};
      qcmr_pkg::RegOutZp:  prdata = {{(qcmr_pkg::WordW-ZW){1'b0}}, out_zero_point};
      qcmr_pkg::RegActUns: prdata = {{(qcmr_pkg::WordW-1){1'b0}}, act_unsigned};
      qcmr_pkg::RegWtUns:  prdata = {{(qcmr_pkg::WordW-1){1'b0}}, wt_unsigned};
      qcmr_pkg::RegOutUns: prdata = {{(qcmr_pkg::WordW-1){1'b0}}, out_unsigned};
      qcmr_pkg::RegShift:  prdata = {{(qcmr_pkg::WordW-SW){1'b0}}, requant_shift};
      default:             prdata = '0;
    endcase
  end

  assign mac_cfg.act_zp  = act_zero_point;
  assign mac_cfg.wt_zp   = wt_zero_point;
  assign mac_cfg.act_uns = act_unsigned;
  assign mac_cfg.wt_uns  = wt_unsigned;
  assign rq_cfg.out_zp   = out_zero_point;
  assign rq_cfg.out_uns  = out_unsigned;
  assign rq_cfg.shift    = requant_shift;

  qcmr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (mac_cfg),
    .tap       (tap),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  qcmr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  qcmr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (rq_cfg),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .res      (res)
  );

endmodule
